@@ rtl/tcc_pkg.sv @@
package tcc_pkg;

   localparam int DEF_ELAPSED_COUNTERS = 8;
   localparam int DEF_LAMP_CHANNELS    = 4;
   localparam int MASK_BITS            = 17;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   localparam logic [9:0] MILLI_LAST  = 10'd999;
   localparam logic [5:0] SECOND_LAST = 6'd59;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [4:0] HOUR_LAST   = 5'd23;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [4:0]  slot;
      logic [2:0]  counter_sel;
      logic [31:0] load_value;
   } req_payload_type;

   typedef struct packed {
      logic [16:0] zero_mask;
      logic [4:0]  hour_now;
      logic [5:0]  minute_now;
      logic [5:0]  second_now;
      logic [9:0]  milli_now;
      logic        second_pulse;
      logic [31:0] slot_value;
      logic [31:0] elapsed_value;
   } rsp_payload_type;

   // control from the top level to the counter banks
   typedef struct packed {
      logic apply;
      logic tick;
      logic roll;
      logic load;
      logic clear;
   } ctl_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] milli;
      logic       pulse;
   } day_type;

endpackage

@@ rtl/tcc_req_if.sv @@
interface tcc_req_if;
   import tcc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tcc_rsp_if.sv @@
interface tcc_rsp_if;
   import tcc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tick_clock_with_countdowns_unit.sv @@
// Millisecond time-of-day clock with saturating countdown slots and free-running
// elapsed counters. Each request word (tick, load slot, clear counter, read) yields
// one result word showing the state after that request. One word is taken every
// clock while the result side does not stall. A taken word is held in the input
// register until the result register can take it, then passes through the counter
// update logic into the result register, from which the result is shown.
// All counters are plain registers updated in parallel, so a tick costs no more
// than a read. The result register lets a new word enter while a result waits.
module tick_clock_with_countdowns_unit #(
   parameter int ELAPSED_COUNTERS = tcc_pkg::DEF_ELAPSED_COUNTERS,
   parameter int LAMP_CHANNELS    = tcc_pkg::DEF_LAMP_CHANNELS
) (
   input  logic      clock,
   input  logic      reset,
   tcc_req_if.sink   req_ch,
   tcc_rsp_if.source rsp_ch
);
   import tcc_pkg::*;

   logic            in_valid_ff;
   req_payload_type in_ff;
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;

   logic     advance;
   logic     tick_go;
   ctl_type  ctl;
   day_type  day_next;
   logic [MASK_BITS-1:0] zero_mask;
   logic [31:0] slot_value;
   logic [31:0] elapsed_value;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign tick_go      = advance && (in_ff.req_type == REQ_TICK);

   always_comb begin
      ctl       = '0;
      ctl.apply = advance;
      ctl.roll  = day_next.pulse;
      case (in_ff.req_type)
         REQ_TICK:  ctl.tick  = advance;
         REQ_LOAD:  ctl.load  = advance;
         REQ_CLEAR: ctl.clear = advance;
         REQ_READ:  ;
         default:   ;
      endcase
   end

   tcc_day_clock u_day_clock (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick_go),
      .day_next (day_next)
   );

   tcc_countdown_bank #(
      .LAMP_CHANNELS (LAMP_CHANNELS)
   ) u_countdown (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .slot       (in_ff.slot),
      .load_value (in_ff.load_value),
      .zero_mask  (zero_mask),
      .slot_value (slot_value)
   );

   tcc_elapsed_bank #(
      .ELAPSED_COUNTERS (ELAPSED_COUNTERS)
   ) u_elapsed (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .counter_sel   (in_ff.counter_sel),
      .elapsed_value (elapsed_value)
   );

   always_comb begin
      out_in.zero_mask     = zero_mask;
      out_in.hour_now      = day_next.hour;
      out_in.minute_now    = day_next.minute;
      out_in.second_now    = day_next.second;
      out_in.milli_now     = day_next.milli;
      out_in.second_pulse  = day_next.pulse;
      out_in.slot_value    = slot_value;
      out_in.elapsed_value = elapsed_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff <= req_ch.payload;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

`ifndef SYNTHESIS
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_ch.valid)
      else $error("word moved to result stage but no result shown");

   a_pulse_at_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.second_pulse) |-> (rsp_ch.payload.milli_now == 10'd0))
      else $error("second pulse without millisecond wrap");

   a_clock_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.payload.milli_now <= MILLI_LAST
                        && rsp_ch.payload.second_now <= SECOND_LAST
                        && rsp_ch.payload.minute_now <= MINUTE_LAST
                        && rsp_ch.payload.hour_now <= HOUR_LAST))
      else $error("day clock out of range");
`endif

endmodule

@@ rtl/tcc_day_clock.sv @@
module tcc_day_clock (
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   output tcc_pkg::day_type day_next
);
   import tcc_pkg::*;

   logic [9:0] milli_ff, milli_in;
   logic [5:0] second_ff, second_in;
   logic [5:0] minute_ff, minute_in;
   logic [4:0] hour_ff, hour_in;
   logic       pulse_in;

   // cascade: milliseconds move on each tick; each stage above only moves when the one below wraps
   always_comb begin
      milli_in  = milli_ff;
      second_in = second_ff;
      minute_in = minute_ff;
      hour_in   = hour_ff;
      pulse_in  = 1'b0;
      if (tick) begin
         if (milli_ff < MILLI_LAST) begin
            milli_in = milli_ff + 10'd1;
         end else begin
            milli_in = 10'd0;
            pulse_in = 1'b1;
            if (second_ff < SECOND_LAST) begin
               second_in = second_ff + 6'd1;
            end else begin
               second_in = 6'd0;
               if (minute_ff < MINUTE_LAST) begin
                  minute_in = minute_ff + 6'd1;
               end else begin
                  minute_in = 6'd0;
                  if (hour_ff < HOUR_LAST) begin
                     hour_in = hour_ff + 5'd1;
                  end else begin
                     hour_in = 5'd0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         milli_ff  <= 10'd0;
         second_ff <= 6'd0;
         minute_ff <= 6'd0;
         hour_ff   <= 5'd0;
      end else begin
         milli_ff  <= milli_in;
         second_ff <= second_in;
         minute_ff <= minute_in;
         hour_ff   <= hour_in;
      end
   end

   assign day_next.hour   = hour_in;
   assign day_next.minute = minute_in;
   assign day_next.second = second_in;
   assign day_next.milli  = milli_in;
   assign day_next.pulse  = pulse_in;

endmodule

@@ rtl/tcc_countdown_bank.sv @@
module tcc_countdown_bank #(
   parameter int LAMP_CHANNELS = tcc_pkg::DEF_LAMP_CHANNELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tcc_pkg::ctl_type                ctl,
   input  logic [4:0]                      slot,
   input  logic [31:0]                     load_value,
   output logic [tcc_pkg::MASK_BITS-1:0]   zero_mask,
   output logic [31:0]                     slot_value
);
   import tcc_pkg::*;

   localparam int SLOT_COUNT = 4 * LAMP_CHANNELS + 1;
   localparam int MASK_USED  = (SLOT_COUNT < MASK_BITS) ? SLOT_COUNT : MASK_BITS;

   logic [31:0] cnt_ff [SLOT_COUNT];
   logic [31:0] cnt_in [SLOT_COUNT];

   // every slot is its own saturating down-counter
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (ctl.roll && (cnt_ff[i] != 32'd0)) begin
            cnt_in[i] = cnt_ff[i] - 32'd1;
         end
         if (ctl.load && ({27'd0, slot} == 32'(i))) begin
            cnt_in[i] = load_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            cnt_ff[i] <= 32'd0;
         end
      end else if (ctl.apply) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // out-of-range slot matches nothing and reads zero
   always_comb begin
      slot_value = 32'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if ({27'd0, slot} == 32'(i)) begin
            slot_value = slot_value | cnt_in[i];
         end
      end
   end

   always_comb begin
      zero_mask = '0;
      for (int i = 0; i < MASK_USED; i++) begin
         zero_mask[i] = (cnt_in[i] == 32'd0);
      end
   end

endmodule

@@ rtl/tcc_elapsed_bank.sv @@
module tcc_elapsed_bank #(
   parameter int ELAPSED_COUNTERS = tcc_pkg::DEF_ELAPSED_COUNTERS
) (
   input  logic             clock,
   input  logic             reset,
   input  tcc_pkg::ctl_type ctl,
   input  logic [2:0]       counter_sel,
   output logic [31:0]      elapsed_value
);
   import tcc_pkg::*;

   logic [31:0] cnt_ff [ELAPSED_COUNTERS];
   logic [31:0] cnt_in [ELAPSED_COUNTERS];

   always_comb begin
      for (int i = 0; i < ELAPSED_COUNTERS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (ctl.tick) begin
            cnt_in[i] = cnt_ff[i] + 32'd1;
         end else if (ctl.clear && ({29'd0, counter_sel} == 32'(i))) begin
            cnt_in[i] = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ELAPSED_COUNTERS; i++) begin
            cnt_ff[i] <= 32'd0;
         end
      end else if (ctl.apply) begin
         for (int i = 0; i < ELAPSED_COUNTERS; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_comb begin
      elapsed_value = 32'd0;
      for (int i = 0; i < ELAPSED_COUNTERS; i++) begin
         if ({29'd0, counter_sel} == 32'(i)) begin
            elapsed_value = elapsed_value | cnt_in[i];
         end
      end
   end

endmodule

@@ bench/tb_tick_clock_with_countdowns_unit.sv @@
module tb_tick_clock_with_countdowns_unit;
   import tcc_pkg::*;

   localparam int ELAPSED_COUNTERS = DEF_ELAPSED_COUNTERS;
   localparam int LAMP_CHANNELS    = DEF_LAMP_CHANNELS;
   localparam int SLOT_COUNT       = 4 * LAMP_CHANNELS + 1;
   localparam int SAVING_SLOT      = 4 * LAMP_CHANNELS;
   localparam int GAP_MAX          = 24;
   localparam int TAIL_CYCLES      = 16;
   localparam int PRINT_CAP        = 50;
   localparam int SEGMENTS         = 2;
   localparam int SEGMENT_WORDS    = 117;

   typedef struct {
      req_payload_type word;
      bit              drain_first;
   } pending_request_type;

   logic clock;
   logic reset;

   tcc_req_if req_ch ();
   tcc_rsp_if rsp_ch ();

   tick_clock_with_countdowns_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow of the block's state
   logic [9:0]  day_milli;
   logic [5:0]  day_second;
   logic [5:0]  day_minute;
   logic [4:0]  day_hour;
   logic [31:0] slot_secs [SLOT_COUNT];
   logic [31:0] elapsed_ms [ELAPSED_COUNTERS];

   pending_request_type request_queue [$];
   rsp_payload_type     status_due [$];
   longint              ticks_queued = 0;
   int                  fail_count = 0;
   int                  results_seen = 0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   bit                  calm = 1'b0;
   int                  calm_left = 0;
   longint              cycle_count = 0;
   longint              cycle_limit = 64'h7FFF_FFFF_FFFF_FFFF;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic rsp_payload_type step_timekeeper(req_payload_type r);
      rsp_payload_type s;
      logic            pulse;
      int              i;
      pulse = 1'b0;
      case (r.req_type)
         REQ_TICK: begin
            for (i = 0; i < ELAPSED_COUNTERS; i++)
               elapsed_ms[i] = elapsed_ms[i] + 32'd1;
            if (day_milli < MILLI_LAST) begin
               day_milli = day_milli + 10'd1;
            end else begin
               day_milli = '0;
               pulse = 1'b1;
               // countdowns saturate at zero
               for (i = 0; i < SLOT_COUNT; i++)
                  if (slot_secs[i] != 32'd0) slot_secs[i] = slot_secs[i] - 32'd1;
               if (day_second < SECOND_LAST) begin
                  day_second = day_second + 6'd1;
               end else begin
                  day_second = '0;
                  if (day_minute < MINUTE_LAST) begin
                     day_minute = day_minute + 6'd1;
                  end else begin
                     day_minute = '0;
                     day_hour = (day_hour < HOUR_LAST) ? day_hour + 5'd1 : 5'd0;
                  end
               end
            end
         end
         REQ_LOAD: begin
            if (r.slot < SLOT_COUNT) slot_secs[r.slot] = r.load_value;
         end
         REQ_CLEAR: begin
            if (r.counter_sel < ELAPSED_COUNTERS) elapsed_ms[r.counter_sel] = '0;
         end
         default: begin
         end
      endcase
      s.zero_mask = '0;
      for (i = 0; i < SLOT_COUNT && i < MASK_BITS; i++)
         s.zero_mask[i] = (slot_secs[i] == 32'd0);
      s.hour_now      = day_hour;
      s.minute_now    = day_minute;
      s.second_now    = day_second;
      s.milli_now     = day_milli;
      s.second_pulse  = pulse;
      s.slot_value    = (r.slot < SLOT_COUNT) ? slot_secs[r.slot] : 32'd0;
      s.elapsed_value = (r.counter_sel < ELAPSED_COUNTERS) ? elapsed_ms[r.counter_sel] : 32'd0;
      return s;
   endfunction

   task automatic report_mismatch(string what);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("mismatch at result %0d: %s", results_seen, what);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, GAP_MAX);
   endfunction

   function automatic logic [31:0] pick_load_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 32'($urandom_range(0, 3));
      if (r < 40) return 32'hFFFF_FFFF;
      if (r < 45) return 32'h0;
      return 32'($urandom);
   endfunction

   function automatic logic [4:0] pick_slot();
      if ($urandom_range(0, 99) < 85) return 5'($urandom_range(0, SLOT_COUNT - 1));
      return 5'($urandom_range(SLOT_COUNT, 31));
   endfunction

   task automatic queue_request(logic [1:0] kind, logic [4:0] slot, logic [2:0] sel,
                                logic [31:0] value, bit drain);
      pending_request_type p;
      p.word.req_type    = kind;
      p.word.slot        = slot;
      p.word.counter_sel = sel;
      p.word.load_value  = value;
      p.drain_first      = drain;
      request_queue.push_back(p);
      if (kind == REQ_TICK) ticks_queued++;
   endtask

   task automatic queue_random_request(bit drain);
      int         roll;
      logic [1:0] kind;
      roll = $urandom_range(0, 99);
      if (roll < 35)      kind = REQ_TICK;
      else if (roll < 60) kind = REQ_LOAD;
      else if (roll < 70) kind = REQ_CLEAR;
      else                kind = REQ_READ;
      queue_request(kind, pick_slot(), 3'($urandom_range(0, 7)), pick_load_value(), drain);
   endtask

   // ticks with random read selects until the tick count hits the wanted phase
   task automatic run_ticks_to(longint period, longint phase);
      while (ticks_queued % period != phase)
         queue_request(REQ_TICK, pick_slot(), 3'($urandom_range(0, 7)), 32'($urandom), 1'b0);
   endtask

   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm <= ~calm;
         calm_left = calm ? $urandom_range(100, 600) : $urandom_range(30, 200);
      end else begin
         calm_left--;
      end
   end

   always @(posedge clock) begin : driver
      pending_request_type p;
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.payload <= '0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            status_due.push_back(step_timekeeper(req_ch.payload));
            send_gap = pick_gap();
         end
         if (req_ch.valid && !req_ch.ready) begin
            // word held until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (request_queue.size() > 0 &&
                      !(request_queue[0].drain_first && status_due.size() > 0)) begin
            p = request_queue.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.payload <= p.word;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (status_due.size() == 0) begin
               report_mismatch("result word with nothing due");
            end else begin
               want = status_due.pop_front();
               check_field("zero_mask", got.zero_mask, want.zero_mask);
               check_field("hour_now", got.hour_now, want.hour_now);
               check_field("minute_now", got.minute_now, want.minute_now);
               check_field("second_now", got.second_now, want.second_now);
               check_field("milli_now", got.milli_now, want.milli_now);
               check_field("second_pulse", got.second_pulse, want.second_pulse);
               check_field("slot_value", got.slot_value, want.slot_value);
               check_field("elapsed_value", got.elapsed_value, want.elapsed_value);
            end
            results_seen++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int i;
      int seg;
      int k;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      day_milli      = '0;
      day_second     = '0;
      day_minute     = '0;
      day_hour       = '0;
      for (i = 0; i < SLOT_COUNT; i++) slot_secs[i] = '0;
      for (i = 0; i < ELAPSED_COUNTERS; i++) elapsed_ms[i] = '0;

      // directed words
      queue_request(REQ_READ, 5'd0, 3'd0, 32'h0, 1'b0);
      queue_request(REQ_LOAD, 5'd0, 3'd0, 32'hFFFF_FFFF, 1'b0);
      queue_request(REQ_LOAD, 5'(SAVING_SLOT), 3'd7, 32'd1, 1'b0);
      queue_request(REQ_LOAD, 5'd15, 3'd3, 32'd2, 1'b0);
      queue_request(REQ_LOAD, 5'd8, 3'd1, 32'h8000_0000, 1'b0);
      queue_request(REQ_LOAD, 5'd17, 3'd2, 32'd5, 1'b0);        // slot past the end
      queue_request(REQ_READ, 5'd31, 3'd7, 32'hFFFF_FFFF, 1'b0);
      queue_request(REQ_TICK, 5'(SAVING_SLOT), 3'd7, 32'h0, 1'b0);
      queue_request(REQ_TICK, 5'd0, 3'd0, 32'hFFFF_FFFF, 1'b0);
      queue_request(REQ_CLEAR, 5'd0, 3'd7, 32'h0, 1'b0);
      queue_request(REQ_CLEAR, 5'd31, 3'd0, 32'h0, 1'b0);
      queue_request(REQ_LOAD, 5'd0, 3'd5, 32'h0, 1'b0);
      queue_request(REQ_LOAD, 5'd4, 3'd2, 32'd3, 1'b0);
      queue_request(REQ_READ, 5'(SAVING_SLOT), 3'd4, 32'h0, 1'b1);
      // second rollover: slot 16 reaches zero, slot 15 drops to one, zero slots hold
      run_ticks_to(1000, 999);
      queue_request(REQ_TICK, 5'(SAVING_SLOT), 3'd7, 32'h0, 1'b0);
      queue_request(REQ_READ, 5'd15, 3'd0, 32'h0, 1'b0);
      queue_request(REQ_READ, 5'd8, 3'd7, 32'h0, 1'b0);
      // first tick after the rollover: no pulse
      queue_request(REQ_TICK, 5'd15, 3'd1, 32'h0, 1'b0);
      queue_request(REQ_READ, 5'(SAVING_SLOT), 3'd6, 32'h0, 1'b0);

      // random segments
      for (seg = 0; seg < SEGMENTS; seg++) begin
         for (k = 0; k < SEGMENT_WORDS; k++)
            queue_random_request(k == 0 && seg % 3 == 0);
      end

      cycle_limit = 3 * longint'(request_queue.size()) * (2 * GAP_MAX + 8) + 20000;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (request_queue.size() > 0 || req_ch.valid || status_due.size() > 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
